/* rtl/tst_pkg.sv */
// tst_pkg: shared types, constants and helpers for the timer slot table.
// Used by timer_slot_table_unit; no dependencies.
`timescale 1ns / 1ps

package tst_pkg;

    // Default table size and fixed result limits
    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int NRES_W         = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] LATE_WINDOW = 32'h7000_0000;

    // Opcodes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SETUP   = 3'd1;
    localparam logic [2:0] OP_CLOSE   = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  slot;
        logic [31:0] period;
        logic        one_shot;
        logic        has_action;
    } t_in_item;

    typedef struct packed {
        logic [3:0] result_slot;
        logic       ok;
        logic       expired_flag;
        logic       fired;
        logic       last;
    } t_out_item;

    // One table entry in memory
    typedef struct packed {
        logic [31:0] period;
        logic [31:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Expiry is now + period, with zero moved to one
    function automatic logic [31:0] arm_expiry(input logic [31:0] now,
                                               input logic [31:0] period);
        logic [31:0] e;
        e = now + period;
        if (e == 32'd0) begin
            e = 32'd1;
        end
        return e;
    endfunction

endpackage

/* rtl/tst_ram.sv */
// tst_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/timer_slot_table_unit.sv */
// timer_slot_table_unit: table of software timer slots with a tick count.
// Depends on tst_pkg and tst_ram.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (i_in_valid / o_in_stall / i_in_item) takes one op item:
//   tick, setup, close, restart or query. One op is worked at a time;
//   o_in_stall is high while an op is in progress.
// - Output channel (o_out_valid / i_out_stall / o_out_item) returns results;
//   the final result of each op has last set. A tick gives one result per
//   firing slot with an action (at most 16), or one empty result.
// - Sequencing: close, query and unused ops go straight to the result state;
//   restart reads the stored period, then re-arms it; setup scans up from
//   slot 0 to the lowest free slot; tick reads one slot per cycle from the
//   period/expiry RAM unless paused (see below); the RAM read port sets the rate.
// - A new op is taken in the cycle after the final result is loaded into the
//   output register, even while that result still waits.
// - When the receiver stalls, the output register holds and the tick scan
//   pauses whenever a second fire result needs the output register.
// - Reset (synchronous, active low) clears the tick count, all slot flags and
//   the output valid; RAM contents are only used for slots in use.

module timer_slot_table_unit
    import tst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SETUP   = 3'd1;
    localparam logic [2:0] S_RESTART = 3'd2;
    localparam logic [2:0] S_TICK    = 3'd3;
    localparam logic [2:0] S_RESULT  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [31:0]           r_now, n_now;
    t_in_item              r_req, n_req;
    logic [CW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_ev_valid, n_ev_valid;
    logic [IW-1:0]         r_ev_idx, n_ev_idx;
    logic [NRES_W-1:0]     r_nres, n_nres;
    logic                  r_pend_valid, n_pend_valid;
    logic [3:0]            r_pend_slot, n_pend_slot;
    t_out_item             r_res, n_res;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    logic [SLOT_COUNT-1:0] r_one_shot, n_one_shot;
    logic [SLOT_COUNT-1:0] r_has_action, n_has_action;
    logic [SLOT_COUNT-1:0] r_expired, n_expired;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  ram_we, ram_re;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    t_entry                ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0]    ram_rdata_raw;

    logic                  push;
    t_out_item             push_item;
    logic                  out_free;
    logic [IW-1:0]         in_idx, req_idx, scan_idx;
    logic                  in_slot_ok;
    logic                  fire, report, hold, issue;

    // Period and expiry storage
    tst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_idx     = IW'(i_in_item.slot);
    assign req_idx    = IW'(r_req.slot);
    assign scan_idx   = r_rd_idx[IW-1:0];
    assign in_slot_ok = 32'(i_in_item.slot) < SLOT_COUNT;

    // Tick evaluation of the slot whose entry is on the RAM output
    assign fire = r_ev_valid && r_in_use[r_ev_idx] && !r_expired[r_ev_idx]
                  && (r_now >= ram_rdata.expiry)
                  && ((r_now - ram_rdata.expiry) < LATE_WINDOW);
    assign report = fire && r_has_action[r_ev_idx] && (r_nres < NRES_W'(MAX_RESULTS));
    assign hold   = report && r_pend_valid && !out_free;
    assign issue  = r_rd_idx < CW'(SLOT_COUNT);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_req        = r_req;
        n_rd_idx     = r_rd_idx;
        n_ev_valid   = r_ev_valid;
        n_ev_idx     = r_ev_idx;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_res        = r_res;
        n_in_use     = r_in_use;
        n_one_shot   = r_one_shot;
        n_has_action = r_has_action;
        n_expired    = r_expired;
        ram_we       = 1'b0;
        ram_waddr    = req_idx;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = in_idx;
        push         = 1'b0;
        push_item    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_item;
                    n_res = '0;
                    n_res.result_slot = i_in_item.slot;
                    n_res.last = 1'b1;
                    case (i_in_item.opcode)
                        OP_TICK: begin
                            n_now        = r_now + 32'd1;
                            n_rd_idx     = '0;
                            n_ev_valid   = 1'b0;
                            n_nres       = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_TICK;
                        end
                        OP_SETUP: begin
                            n_rd_idx = '0;
                            n_state  = S_SETUP;
                        end
                        OP_CLOSE: begin
                            if (in_slot_ok) begin
                                n_in_use[in_idx]     = 1'b0;
                                n_one_shot[in_idx]   = 1'b0;
                                n_has_action[in_idx] = 1'b0;
                                n_expired[in_idx]    = 1'b0;
                            end
                            n_state = S_RESULT;
                        end
                        OP_RESTART: begin
                            if (in_slot_ok && r_in_use[in_idx]) begin
                                ram_re  = 1'b1;
                                n_state = S_RESTART;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        OP_QUERY: begin
                            n_res.expired_flag = (in_slot_ok && r_in_use[in_idx])
                                                 ? r_expired[in_idx] : 1'b1;
                            n_state = S_RESULT;
                        end
                        default: begin
                            n_res.result_slot = '0;
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end

            // Find the lowest free slot, one per cycle
            S_SETUP: begin
                if (!r_in_use[scan_idx]) begin
                    n_in_use[scan_idx]     = 1'b1;
                    n_one_shot[scan_idx]   = r_req.one_shot;
                    n_has_action[scan_idx] = r_req.has_action;
                    n_expired[scan_idx]    = 1'b0;
                    ram_we           = 1'b1;
                    ram_waddr        = scan_idx;
                    ram_wdata.period = r_req.period;
                    ram_wdata.expiry = arm_expiry(r_now, r_req.period);
                    n_res             = '0;
                    n_res.result_slot = 4'(scan_idx);
                    n_res.ok          = 1'b1;
                    n_res.last        = 1'b1;
                    n_state           = S_RESULT;
                end else if (r_rd_idx == CW'(SLOT_COUNT - 1)) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_state    = S_RESULT;
                end else begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
            end

            // Re-arm from the stored period
            S_RESTART: begin
                ram_we           = 1'b1;
                ram_waddr        = req_idx;
                ram_wdata.period = ram_rdata.period;
                ram_wdata.expiry = arm_expiry(r_now, ram_rdata.period);
                n_expired[req_idx] = 1'b0;
                n_res.ok = 1'b1;
                n_state  = S_RESULT;
            end

            // Scan: read slot k while slot k-1 is evaluated
            S_TICK: begin
                if (!hold) begin
                    if (fire) begin
                        if (r_has_action[r_ev_idx]) begin
                            n_expired[r_ev_idx] = 1'b1;
                        end
                        if (r_one_shot[r_ev_idx]) begin
                            n_in_use[r_ev_idx]     = 1'b0;
                            n_one_shot[r_ev_idx]   = 1'b0;
                            n_has_action[r_ev_idx] = 1'b0;
                            n_expired[r_ev_idx]    = 1'b0;
                        end
                    end
                    // Newest fire result is held back until we know if it is last
                    if (report) begin
                        if (r_pend_valid) begin
                            push                  = 1'b1;
                            push_item.result_slot = r_pend_slot;
                            push_item.fired       = 1'b1;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = 4'(r_ev_idx);
                        n_nres       = r_nres + NRES_W'(1);
                    end
                    n_ev_valid = issue;
                    n_ev_idx   = scan_idx;
                    if (issue) begin
                        ram_re    = 1'b1;
                        ram_raddr = scan_idx;
                        n_rd_idx  = r_rd_idx + CW'(1);
                    end else if (!r_ev_valid) begin
                        n_res             = '0;
                        n_res.result_slot = r_pend_valid ? r_pend_slot : 4'd0;
                        n_res.fired       = r_pend_valid;
                        n_res.last        = 1'b1;
                        n_state           = S_RESULT;
                    end
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_item = r_res;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_rd_idx     <= '0;
            r_ev_valid   <= 1'b0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_in_use     <= '0;
            r_one_shot   <= '0;
            r_has_action <= '0;
            r_expired    <= '0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_rd_idx     <= n_rd_idx;
            r_ev_valid   <= n_ev_valid;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_in_use     <= n_in_use;
            r_one_shot   <= n_one_shot;
            r_has_action <= n_has_action;
            r_expired    <= n_expired;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_ev_idx    <= n_ev_idx;
        r_pend_slot <= n_pend_slot;
        r_res       <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_item <= push_item;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
